// ===== sv/awu_pkg.sv =====
// ----------------------------------------------------------------------------
// Adam weight update package
// Shared constants, register codes and the structs that travel between the
// front, the moment queue, the moment stage and the step pipeline.
// ----------------------------------------------------------------------------
package awu_pkg;

	// Number of weight elements with stored moments.
	localparam int ELEMENTS = 4096;
	localparam int ADDR_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

	// Field widths.
	localparam int IDX_W = 12;
	localparam int ROOT_W = 32;
	localparam int QUOT_W = 34;

	// Queue depths.
	localparam int MQ_DEPTH = 4;
	localparam int OQ_DEPTH = 4;

	// Configuration port.
	localparam int APB_ADDR_W = 4;
	localparam logic [1:0] REG_BETA_ONE = 2'd0;
	localparam logic [1:0] REG_BETA_TWO = 2'd1;
	localparam logic [1:0] REG_EPSILON = 2'd2;
	localparam logic [1:0] REG_STEP_SIZE = 2'd3;

	localparam logic [15:0] BETA_ONE_RST = 16'd58982;
	localparam logic [15:0] BETA_TWO_RST = 16'd65470;
	localparam logic [15:0] EPSILON_RST = 16'd1;
	localparam logic [23:0] STEP_SIZE_RST = 24'd16777;

	typedef struct packed {
		logic [15:0] beta_one;
		logic [15:0] beta_two;
		logic [15:0] epsilon;
		logic [23:0] step_size;
	} cfg_t;

	// Classified item waiting for the moment stage.
	typedef struct packed {
		logic hit;
		logic [IDX_W-1:0] idx;
		logic signed [31:0] w;
		logic [63:0] g2;
		logic signed [48:0] pm;
	} mq_t;

	// Item with its updated moments.
	typedef struct packed {
		logic valid;
		logic hit;
		logic sat;
		logic [IDX_W-1:0] idx;
		logic signed [31:0] w;
		logic signed [31:0] m;
		logic [63:0] v;
	} mv_t;

	// Finished result.
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic signed [31:0] w;
		logic sat;
	} res_t;

endpackage

// ===== sv/awu_front.sv =====
// ----------------------------------------------------------------------------
// Adam weight update front
// Takes input items, marks whether the index has stored moments and forms the
// gradient square and the weighted gradient for the moment stage.
// ----------------------------------------------------------------------------
module awu_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [awu_pkg::IDX_W-1:0] elem_index,
	input logic signed [31:0] gradient,
	input logic signed [31:0] weight_in,
	input awu_pkg::cfg_t cfg,
	input logic clearing,
	output logic mq_push,
	output awu_pkg::mq_t mq_data,
	input logic mq_full
);
	import awu_pkg::*;

	logic valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic signed [31:0] g_s1;
	logic signed [31:0] w_s1;
	logic accept;
	logic [31:0] g_mag;
	logic [16:0] c1;

	assign mq_push = valid_s1 && !mq_full;
	assign full = clearing || (valid_s1 && mq_full);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (mq_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= elem_index;
			g_s1 <= gradient;
			w_s1 <= weight_in;
		end
	end

	always_comb begin
		g_mag = g_s1[31] ? 32'(-g_s1) : 32'(g_s1);
		c1 = 17'h10000 - {1'b0, cfg.beta_one};
		mq_data.hit = ({20'b0, idx_s1} < 32'(ELEMENTS));
		mq_data.idx = idx_s1;
		mq_data.w = w_s1;
		mq_data.g2 = 64'(g_mag) * 64'(g_mag);
		mq_data.pm = 49'($signed({1'b0, c1})) * 49'(g_s1);
	end

endmodule

// ===== sv/awu_queue.sv =====
// ----------------------------------------------------------------------------
// Adam weight update moment queue
// Short queue that lets the front and the moment stage stall on their own.
// ----------------------------------------------------------------------------
module awu_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input awu_pkg::mq_t wr_data,
	output logic q_full,
	input logic rd_en,
	output awu_pkg::mq_t rd_data,
	output logic q_empty
);
	import awu_pkg::*;

	localparam int PTR_W = (MQ_DEPTH > 1) ? $clog2(MQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(MQ_DEPTH + 1);

	mq_t slot_q [MQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_full = (cnt_q == CNT_W'(MQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(MQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(MQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== sv/awu_moments.sv =====
// ----------------------------------------------------------------------------
// Adam weight update moment stage
// Reads the stored moments of an element, blends in the new gradient and
// writes them back, forwarding the last write to a following item.
// ----------------------------------------------------------------------------
module awu_moments (
	input logic clk,
	input logic arst_n,
	input awu_pkg::cfg_t cfg,
	input logic adv,
	input logic mq_empty,
	input awu_pkg::mq_t mq_head,
	output logic mq_pop,
	output logic clearing,
	output awu_pkg::mv_t mv
);
	import awu_pkg::*;

	logic clr_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic valid_s1;
	mq_t it_s1;
	logic [16:0] c2;
	logic [80:0] pv;
	logic [ADDR_W-1:0] addr_s1;

	logic valid_s2;
	logic hit_s2;
	logic [IDX_W-1:0] idx_s2;
	logic signed [31:0] w_s2;
	logic signed [48:0] pm_s2;
	logic [80:0] pv_s2;
	logic [ADDR_W-1:0] addr_s2;

	logic signed [31:0] rd_m_q;
	logic [63:0] rd_v_q;
	logic lw_valid_q;
	logic [ADDR_W-1:0] lw_addr_q;
	logic signed [31:0] lw_m_q;
	logic [63:0] lw_v_q;

	logic fwd;
	logic signed [31:0] old_m;
	logic [63:0] old_v;
	logic signed [50:0] msum;
	logic [81:0] vsum;
	logic msat;
	logic vsat;
	logic signed [31:0] m_new;
	logic [63:0] v_new;
	logic wr_en;

	logic signed [31:0] mem_m [ELEMENTS];
	logic [63:0] mem_v [ELEMENTS];

	assign clearing = clr_q;
	assign mq_pop = adv && !mq_empty && !clr_q;

	// Clearing pass over both moment memories after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == ADDR_W'(ELEMENTS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= mq_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && mq_pop) begin
			it_s1 <= mq_head;
		end
	end

	always_comb begin
		c2 = 17'h10000 - {1'b0, cfg.beta_two};
		pv = 81'(c2) * 81'(it_s1.g2);
		addr_s1 = ADDR_W'(it_s1.idx);
	end

	// Update stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s2 <= it_s1.hit;
			idx_s2 <= it_s1.idx;
			w_s2 <= it_s1.w;
			pm_s2 <= it_s1.pm;
			pv_s2 <= pv;
			addr_s2 <= addr_s1;
			rd_m_q <= mem_m[addr_s1];
			rd_v_q <= mem_v[addr_s1];
		end
	end

	assign wr_en = adv && valid_s2 && hit_s2;

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem_m[clr_cnt_q] <= '0;
			mem_v[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem_m[addr_s2] <= m_new;
			mem_v[addr_s2] <= v_new;
		end
	end

	// The last write is forwarded, since the read for the next item happened
	// at the same edge and saw the old contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (wr_en) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_addr_q <= addr_s2;
			lw_m_q <= m_new;
			lw_v_q <= v_new;
		end
	end

	always_comb begin
		fwd = lw_valid_q && (lw_addr_q == addr_s2);
		old_m = fwd ? lw_m_q : rd_m_q;
		old_v = fwd ? lw_v_q : rd_v_q;
		msum = 51'($signed({1'b0, cfg.beta_one})) * 51'(old_m) + 51'(pm_s2) + 51'sd32768;
		vsum = 82'(cfg.beta_two) * 82'(old_v) + 82'(pv_s2) + 82'd32768;
		msat = (msum[50:47] != {4{msum[47]}});
		vsat = |vsum[81:80];
		if (msat) begin
			m_new = msum[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			m_new = msum[47:16];
		end
		v_new = vsat ? '1 : vsum[79:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv <= '0;
		end else if (adv) begin
			mv.valid <= valid_s2;
			mv.hit <= hit_s2;
			mv.sat <= hit_s2 && (msat || vsat);
			mv.idx <= idx_s2;
			mv.w <= w_s2;
			mv.m <= m_new;
			mv.v <= v_new;
		end
	end

endmodule

// ===== sv/awu_step.sv =====
// ----------------------------------------------------------------------------
// Adam weight update step pipeline
// Square root of the second moment, rounded division of the scaled first
// moment by the denominator, and the saturated weight update.
// ----------------------------------------------------------------------------
module awu_step (
	input logic clk,
	input logic arst_n,
	input awu_pkg::cfg_t cfg,
	input logic adv,
	input awu_pkg::mv_t mv,
	output logic res_valid,
	output awu_pkg::res_t res_data
);
	import awu_pkg::*;

	localparam int V_W = 2 * ROOT_W;
	localparam int TRIAL_W = V_W + 2;
	localparam int DEN_W = ROOT_W + 1;
	localparam int DIV_W = DEN_W + 8;
	localparam int NUM_W = 24 + ROOT_W;
	localparam int EXT_W = DIV_W + QUOT_W;
	localparam int SUM_W = QUOT_W + 2;

	typedef struct packed {
		logic valid;
		logic hit;
		logic sat;
		logic [IDX_W-1:0] idx;
		logic signed [31:0] w;
		logic signed [31:0] m;
		logic [V_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic sat;
		logic neg;
		logic [IDX_W-1:0] idx;
		logic signed [31:0] w;
		logic ovf;
		logic [NUM_W-1:0] rem;
		logic [DIV_W-1:0] d;
		logic [QUOT_W-1:0] quot;
	} dv_t;

	sq_t sq_s [ROOT_W+1];
	dv_t dv_s [QUOT_W+1];

	logic [DEN_W-1:0] den;
	logic [31:0] mag_m;
	logic [QUOT_W-1:0] step;
	logic signed [SUM_W-1:0] wsum;
	logic wsat;

	always_comb begin
		sq_s[0].valid = mv.valid;
		sq_s[0].hit = mv.hit;
		sq_s[0].sat = mv.sat;
		sq_s[0].idx = mv.idx;
		sq_s[0].w = mv.w;
		sq_s[0].m = mv.m;
		sq_s[0].rem = mv.v;
		sq_s[0].root = '0;
	end

	// One root bit per stage, remainder kept as v - root^2.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - k;
		logic [TRIAL_W-1:0] trial;
		sq_t nxt;

		always_comb begin
			trial = (TRIAL_W'(sq_s[k].root) << (B + 1)) + (TRIAL_W'(1) << (2 * B));
			nxt = sq_s[k];
			if (TRIAL_W'(sq_s[k].rem) >= trial) begin
				nxt.rem = sq_s[k].rem - trial[V_W-1:0];
				nxt.root = sq_s[k].root | (ROOT_W'(1) << B);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_s[k+1] <= '0;
			end else if (adv) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// Denominator and rounded numerator.
	always_comb begin
		den = DEN_W'(sq_s[ROOT_W].root) + DEN_W'(cfg.epsilon);
		if (den == '0) begin
			den = DEN_W'(1);
		end
		mag_m = sq_s[ROOT_W].m[31] ? 32'(-sq_s[ROOT_W].m) : 32'(sq_s[ROOT_W].m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= '0;
		end else if (adv) begin
			dv_s[0].valid <= sq_s[ROOT_W].valid;
			dv_s[0].hit <= sq_s[ROOT_W].hit;
			dv_s[0].sat <= sq_s[ROOT_W].sat;
			dv_s[0].neg <= sq_s[ROOT_W].m[31];
			dv_s[0].idx <= sq_s[ROOT_W].idx;
			dv_s[0].w <= sq_s[ROOT_W].w;
			dv_s[0].ovf <= 1'b0;
			dv_s[0].rem <= NUM_W'(cfg.step_size) * NUM_W'(mag_m) + NUM_W'({den, 7'b0});
			dv_s[0].d <= {den, 8'b0};
			dv_s[0].quot <= '0;
		end
	end

	// One quotient bit per stage. A quotient too large for the field always
	// saturates the weight, so it is only flagged.
	for (genvar k = 0; k < QUOT_W; k++) begin : g_div
		localparam int B = QUOT_W - 1 - k;
		logic [EXT_W-1:0] shd;
		dv_t nxt;

		always_comb begin
			shd = EXT_W'(dv_s[k].d) << B;
			nxt = dv_s[k];
			if (k == 0) begin
				nxt.ovf = (EXT_W'(dv_s[k].rem) >= (EXT_W'(dv_s[k].d) << QUOT_W));
			end
			if (EXT_W'(dv_s[k].rem) >= shd) begin
				nxt.rem = dv_s[k].rem - shd[NUM_W-1:0];
				nxt.quot[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= '0;
			end else if (adv) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	// Weight update with saturation.
	always_comb begin
		step = dv_s[QUOT_W].ovf ? '1 : dv_s[QUOT_W].quot;
		if (dv_s[QUOT_W].neg) begin
			wsum = SUM_W'(dv_s[QUOT_W].w) - $signed({2'b0, step});
		end else begin
			wsum = SUM_W'(dv_s[QUOT_W].w) + $signed({2'b0, step});
		end
		wsat = (wsum[SUM_W-1:31] != {(SUM_W - 31){wsum[31]}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= dv_s[QUOT_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_data.idx <= dv_s[QUOT_W].idx;
			if (!dv_s[QUOT_W].hit) begin
				res_data.w <= dv_s[QUOT_W].w;
				res_data.sat <= 1'b0;
			end else if (wsat) begin
				res_data.w <= wsum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				res_data.sat <= 1'b1;
			end else begin
				res_data.w <= wsum[31:0];
				res_data.sat <= dv_s[QUOT_W].sat;
			end
		end
	end

endmodule

// ===== sv/adam_weight_update.sv =====
// ----------------------------------------------------------------------------
// Adam weight update
// Per-element Adam step without bias correction, in fixed point, with stored
// first and second moments and a queue-style stream interface.
// ----------------------------------------------------------------------------
// The block takes one gradient item per clock while full stays low and returns
// one updated weight per item, in order. The rate is set by the moment
// memories: each item reads its element's moments in the read stage and
// writes them back from the update stage, and an item for the same element
// right behind gets the fresh values through a forwarding register, so
// repeated indices keep the full rate. The square root (one bit per stage,
// 32 stages) and the rounded division (one bit per stage, 34 stages) are
// fully pipelined. After reset the block clears both moment memories, one
// element per cycle; full stays high during that pass, while the
// configuration port is usable throughout. When results are not taken, the
// whole back end holds and a small queue in front of it keeps accepting
// items until it fills.
module adam_weight_update (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [awu_pkg::APB_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic push,
	output logic full,
	input logic [awu_pkg::IDX_W-1:0] elem_index,
	input logic signed [31:0] gradient,
	input logic signed [31:0] weight_in,
	output logic empty,
	input logic pop,
	output logic [awu_pkg::IDX_W-1:0] elem_out,
	output logic signed [31:0] weight_out,
	output logic saturated
);
	import awu_pkg::*;

	localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	cfg_t cfg_q;
	logic cfg_wr;

	logic clearing;
	logic mq_push;
	mq_t mq_wdata;
	logic mq_full;
	logic mq_pop;
	mq_t mq_head;
	logic mq_empty;
	mv_t mv;
	logic adv;
	logic res_valid;
	res_t res_data;

	res_t oq_slot_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;
	logic oq_full;
	logic oq_push;
	logic oq_pop;
	res_t oq_head;

	// Configuration registers. The port never waits.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beta_one <= BETA_ONE_RST;
			cfg_q.beta_two <= BETA_TWO_RST;
			cfg_q.epsilon <= EPSILON_RST;
			cfg_q.step_size <= STEP_SIZE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_BETA_ONE: begin
					cfg_q.beta_one <= pwdata[15:0];
				end
				REG_BETA_TWO: begin
					cfg_q.beta_two <= pwdata[15:0];
				end
				REG_EPSILON: begin
					cfg_q.epsilon <= pwdata[15:0];
				end
				REG_STEP_SIZE: begin
					cfg_q.step_size <= pwdata[23:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BETA_ONE: prdata = {16'b0, cfg_q.beta_one};
			REG_BETA_TWO: prdata = {16'b0, cfg_q.beta_two};
			REG_EPSILON: prdata = {16'b0, cfg_q.epsilon};
			REG_STEP_SIZE: prdata = {8'b0, cfg_q.step_size};
			default: prdata = '0;
		endcase
	end

	awu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.elem_index(elem_index),
		.gradient(gradient),
		.weight_in(weight_in),
		.cfg(cfg_q),
		.clearing(clearing),
		.mq_push(mq_push),
		.mq_data(mq_wdata),
		.mq_full(mq_full)
	);

	awu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(mq_push),
		.wr_data(mq_wdata),
		.q_full(mq_full),
		.rd_en(mq_pop),
		.rd_data(mq_head),
		.q_empty(mq_empty)
	);

	awu_moments u_moments (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.adv(adv),
		.mq_empty(mq_empty),
		.mq_head(mq_head),
		.mq_pop(mq_pop),
		.clearing(clearing),
		.mv(mv)
	);

	awu_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.adv(adv),
		.mv(mv),
		.res_valid(res_valid),
		.res_data(res_data)
	);

	// Result queue. The back end moves as long as there is room for one more
	// result, so a stalled consumer freezes the pipeline in place.
	assign oq_full = (oq_cnt_q == OQ_CNT_W'(OQ_DEPTH));
	assign adv = !oq_full;
	assign oq_push = res_valid && adv;
	assign empty = (oq_cnt_q == '0);
	assign oq_pop = pop && !empty;
	assign oq_head = oq_slot_q[oq_rd_q];
	assign elem_out = oq_head.idx;
	assign weight_out = oq_head.w;
	assign saturated = oq_head.sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= (oq_wr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_slot_q[oq_wr_q] <= res_data;
		end
	end

	// No item may enter while the moment memories are being cleared.
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("item could be accepted during the clearing pass");

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue count beyond its depth");

	a_oq_pop_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_pop && !oq_push) |=> (oq_cnt_q == $past(oq_cnt_q) - 1'b1))
		else $error("result queue count did not drop on a pop");

	// A result held back by a full queue must not change or vanish.
	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !adv) |=> (res_valid && $stable(res_data)))
		else $error("stalled result changed");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Adam weight update testbench
// Streams gradient items through the block under random push and pop gaps,
// predicts every updated weight from a private copy of the moments and the
// registers, and compares each result in order, field by field.
// ----------------------------------------------------------------------------
module tb;
	import awu_pkg::*;

	// Expected result of one item.
	typedef struct {
		logic [IDX_W-1:0] idx;
		logic signed [31:0] w;
		logic sat;
	} upd_t;

	// Holds the predicted weights in arrival order and checks popped results.
	class weight_board;
		upd_t pending[$];
		int errors;
		logic [15:0] b1, b2, eps;
		logic [23:0] lr;
		logic signed [31:0] m_mem[ELEMENTS];
		logic [63:0] v_mem[ELEMENTS];

		function void clear();
			b1 = BETA_ONE_RST;
			b2 = BETA_TWO_RST;
			eps = EPSILON_RST;
			lr = STEP_SIZE_RST;
			foreach (m_mem[i]) begin
				m_mem[i] = 0;
				v_mem[i] = 0;
			end
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] r, logic [31:0] d);
			case (r)
				REG_BETA_ONE: b1 = d[15:0];
				REG_BETA_TWO: b2 = d[15:0];
				REG_EPSILON: eps = d[15:0];
				default: lr = d[23:0];
			endcase
		endfunction

		// Bitwise integer square root of a 64-bit value.
		function logic [31:0] root64(logic [63:0] x);
			logic [63:0] r;
			logic [31:0] y;
			logic [63:0] t;
			r = x;
			y = 0;
			for (int i = 31; i >= 0; i--) begin
				t = ({32'd0, y} << (i + 1)) + (64'd1 << (2 * i));
				if (r >= t) begin
					r = r - t;
					y[i] = 1'b1;
				end
			end
			return y;
		endfunction

		// Works out the result of one accepted item and updates the moments.
		function void note_item(logic [IDX_W-1:0] idx, logic signed [31:0] g,
				logic signed [31:0] w);
			upd_t e;
			logic signed [63:0] mw, mm, ws;
			logic [127:0] vw;
			logic [63:0] v, g2, mag, den, q, num;
			logic sat;
			e.idx = idx;
			sat = 0;
			// Every 12-bit index is in range for 4096 elements.
			mw = 64'(signed'({1'b0, b1})) * m_mem[idx]
				+ 64'(signed'({1'b0, 17'd65536 - b1})) * g + 64'sd32768;
			mm = mw >>> 16;
			if (mm > 64'sd2147483647) begin
				mm = 64'sd2147483647;
				sat = 1;
			end else if (mm < -64'sd2147483648) begin
				mm = -64'sd2147483648;
				sat = 1;
			end
			m_mem[idx] = mm[31:0];
			mag = (g < 0) ? 64'(-64'(g)) : 64'(g);
			g2 = mag * mag;
			vw = 128'(b2) * v_mem[idx] + 128'(17'd65536 - b2) * g2 + 128'd32768;
			vw = vw >> 16;
			if (vw[127:64] != 0) begin
				v = '1;
				sat = 1;
			end else
				v = vw[63:0];
			v_mem[idx] = v;
			den = 64'(root64(v)) + 64'(eps);
			if (den == 0)
				den = 1;
			q = den << 8;
			num = 64'(lr) * ((mm < 0) ? 64'(-mm) : 64'(mm));
			ws = (mm < 0) ? 64'(w) - 64'((num + (q >> 1)) / q)
				: 64'(w) + 64'((num + (q >> 1)) / q);
			if (ws > 64'sd2147483647) begin
				ws = 64'sd2147483647;
				sat = 1;
			end else if (ws < -64'sd2147483648) begin
				ws = -64'sd2147483648;
				sat = 1;
			end
			e.w = ws[31:0];
			e.sat = sat;
			pending.push_back(e);
		endfunction

		function void check_result(logic [IDX_W-1:0] idx, logic signed [31:0] w,
				logic sat);
			upd_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result idx=%0d w=%0d sat=%0b", idx, w, sat);
				return;
			end
			e = pending.pop_front();
			if (idx !== e.idx || w !== e.w || sat !== e.sat) begin
				errors++;
				if (errors <= 10)
					$display({"result differs: expected idx=%0d w=%0d sat=%0b,",
						" got idx=%0d w=%0d sat=%0b"},
						e.idx, e.w, e.sat, idx, w, sat);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [APB_ADDR_W-1:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic push = 0;
	logic full;
	logic [IDX_W-1:0] elem_index = 0;
	logic signed [31:0] gradient = 0, weight_in = 0;
	logic empty;
	logic pop = 0;
	logic [IDX_W-1:0] elem_out;
	logic signed [31:0] weight_out;
	logic saturated;

	weight_board board;
	int cycles = 0;
	bit calm = 0;       // no idling in the last part of the run
	bit hold_pop = 0;   // long receiver hold-off requested
	localparam int CYCLE_LIMIT = 400000;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	adam_weight_update u_dut (.*);

	// Watchdog on total run length, generous against the clearing pass and stalls.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("adam_weight_update: mismatch");
			$finish;
		end
	end

	// Receiver: random pop bursts, sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_result(elem_out, weight_out, saturated);
	end

	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_pop) begin
				pop <= 0;
				// Hold results back long enough for the input queue to fill.
				repeat (200) @(negedge clk);
				hold_pop = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 7);
				pop <= 0;
				repeat (n - 1) @(negedge clk);
			end else
				pop <= 1;
		end
	end

	task automatic write_reg(logic [1:0] r, logic [31:0] d);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= APB_ADDR_W'({r, 2'b00});
		pwdata <= d;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_reg(r, d);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	// Offers one item and holds it until the block accepts it.
	task automatic send_item(logic [IDX_W-1:0] idx, logic signed [31:0] g,
			logic signed [31:0] w);
		int n;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 7);
			push <= 0;
			repeat (n) @(negedge clk);
		end
		push <= 1;
		elem_index <= idx;
		gradient <= g;
		weight_in <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_item(idx, g, w);
		// Lowered at the next falling edge unless another item follows.
		fork
			begin
				#1;
			end
		join
	endtask

	task automatic end_stream();
		@(negedge clk);
		push <= 0;
	endtask

	task automatic drain();
		end_stream();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// A small pool of elements makes repeated indices, back to back or close.
	function automatic logic [IDX_W-1:0] pick_index();
		if ($urandom_range(0, 3) == 0)
			return IDX_W'($urandom);
		return IDX_W'($urandom_range(0, 7));
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'(signed'($urandom_range(0, 131072)) - 65536);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			send_item(pick_index(), pick_value(), pick_value());
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: field extremes, the same element repeated, large gradients.
		send_item(0, 0, 0);
		send_item(12'hfff, 32'sh7fffffff, 32'sh7fffffff);
		send_item(12'hfff, 32'sh7fffffff, 32'sh7fffffff);
		send_item(0, 32'sh80000000, 32'sh80000000);
		send_item(0, 32'sh80000000, 32'sh80000000);
		send_item(1, 32'sh00010000, 32'sh7ffffff0);
		send_item(1, 32'shffff0000, 32'sh80000010);
		send_item(2, -1, 0);
		send_item(2, 1, -1);
		send_item(12'haaa, 32'sh55555555, 32'shaaaaaaaa);
		send_item(12'h555, 32'shaaaaaaaa, 32'sh55555555);
		drain();

		// Zero denominator: epsilon 0 on an element whose second moment is 0.
		write_reg(REG_EPSILON, 0);
		write_reg(REG_STEP_SIZE, 24'hffffff);
		send_item(3, 0, 5);
		send_item(4, 0, -5);
		drain();
		// Beta one at zero keeps the gradient as the whole first moment.
		write_reg(REG_BETA_ONE, 0);
		write_reg(REG_BETA_TWO, 0);
		send_item(5, 32'sh7fffffff, 32'sh70000000);
		send_item(5, 32'sh80000000, 32'sh90000000);
		send_item(6, 1, 0);
		drain();

		// Betas at the top of their range, epsilon at its maximum.
		write_reg(REG_BETA_ONE, 16'hffff);
		write_reg(REG_BETA_TWO, 16'hffff);
		write_reg(REG_EPSILON, 16'hffff);
		write_reg(REG_STEP_SIZE, 0);
		random_phase(150);
		drain();

		write_reg(REG_BETA_ONE, $urandom_range(0, 65535));
		write_reg(REG_BETA_TWO, $urandom_range(0, 65535));
		write_reg(REG_EPSILON, $urandom_range(0, 16));
		write_reg(REG_STEP_SIZE, $urandom_range(0, 24'hffffff));
		// Long receiver hold-off while items keep coming, to stall the input.
		hold_pop = 1;
		random_phase(250);
		drain();

		write_reg(REG_BETA_ONE, BETA_ONE_RST);
		write_reg(REG_BETA_TWO, BETA_TWO_RST);
		write_reg(REG_EPSILON, EPSILON_RST);
		write_reg(REG_STEP_SIZE, STEP_SIZE_RST);
		random_phase(150);
		calm = 1;
		random_phase(80);
		drain();

		if (board.errors == 0)
			$display("adam_weight_update: match");
		else
			$display("adam_weight_update: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/awu_pkg.sv
sv/awu_front.sv
sv/awu_queue.sv
sv/awu_moments.sv
sv/awu_step.sv
sv/adam_weight_update.sv
sim/tb.sv
